// File: hdl/irsc_pkg.sv
// Shared types, constants and helpers for the IP range step/check/count unit.
package irsc_pkg;

   localparam int SLOT_BITS     = 16;
   localparam int MAX_GROUPS    = 8;
   localparam int V4_GROUPS     = 4;
   localparam int CNT_BITS      = SLOT_BITS + 1;
   localparam int WORD_BITS     = 64;
   localparam int ADDR_BITS     = 2 * WORD_BITS;
   localparam int CFG_ADDR_BITS = 6;
   localparam int CFG_DATA_BITS = 64;
   localparam int REG_SHIFT     = 3;
   localparam int REG_IDX_BITS  = CFG_ADDR_BITS - REG_SHIFT;

   localparam logic [1:0] CMD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_NEXT   = 2'd1;
   localparam logic [1:0] CMD_CHECK  = 2'd2;
   localparam logic [1:0] CMD_VOLUME = 2'd3;

   localparam logic [REG_IDX_BITS-1:0] REG_IS_V6     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MASKED    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_FROM_HIGH = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_FROM_LOW  = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_TO_HIGH   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_TO_LOW    = 3'd5;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [WORD_BITS-1:0] addr_high;
      logic [WORD_BITS-1:0] addr_low;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] out_high;
      logic [WORD_BITS-1:0] out_low;
      logic                 ok;
      logic [WORD_BITS-1:0] volume;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] first_val;
      logic [SLOT_BITS-1:0] inc_val;
      logic [SLOT_BITS-1:0] carry_val;
      logic [SLOT_BITS-1:0] keep_val;
      logic                 lt;
      logic                 in_rng;
      logic                 empty;
      logic                 eq_inc;
      logic                 eq_carry;
      logic                 eq_keep;
      logic [CNT_BITS-1:0]  cnt;
   } lane_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]                   out_high;
      logic [WORD_BITS-1:0]                   out_low;
      logic                                   ok;
      logic                                   is_vol;
      logic                                   mv4;
      logic                                   empty;
      logic                                   sat;
      logic [WORD_BITS-1:0]                   prod;
      logic [MAX_GROUPS-1:0][CNT_BITS-1:0]    cnt;
   } stage_type;

   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] w,
                                                    input int g);
      return w[ADDR_BITS-1-SLOT_BITS*g -: SLOT_BITS];
   endfunction

endpackage

// File: hdl/ip_range_step_check_count_unit.sv
// Top level of the IP range step/check/count unit: registers, lanes and pipeline control.
//
// Usage: program the range through the APB port (is_v6, masked, from_high, from_low,
// to_high, to_low at byte addresses 0, 8, 16, 24, 32, 40) while no item is in flight.
// Each request item carries a command (first, next, check, volume) and an address;
// each produces exactly one response item.
// Pipeline: the group lanes capture the request item at the accepting edge; it then
// passes the merge stage, the saturating product chain (one group count multiplied
// per stage) and the output register, whose content shows on rsp_valid.
// Throughput: one item per cycle; req_ready stays high while the pipe can move.
// Stall: when rsp_ready is low, items hold in place and empty stages fill up;
// req_ready drops only when all GROUP_COUNT+2 stages are occupied.
// Reset: clears the configuration registers to zero (IPv4, single address 0.0.0.0)
// and empties the pipe.
module ip_range_step_check_count_unit import irsc_pkg::*; #(
   parameter int GROUP_COUNT = 8,
   parameter int GROUP_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CFG_ADDR_BITS-1:0] paddr,
   input  logic [CFG_DATA_BITS-1:0] pwdata,
   output logic [CFG_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int NS = GROUP_COUNT + 2;

   logic                    is_v6_ff;
   logic                    masked_ff;
   logic [WORD_BITS-1:0]    from_high_ff;
   logic [WORD_BITS-1:0]    from_low_ff;
   logic [WORD_BITS-1:0]    to_high_ff;
   logic [WORD_BITS-1:0]    to_low_ff;
   logic                    wr;
   logic [REG_IDX_BITS-1:0] idx;
   logic                    mv4;
   logic [NS:0]             rdy;
   logic [NS-1:0]           vld_ff;
   logic [NS-1:0]           vld_in;
   logic [1:0]              cmd_ff;
   logic [ADDR_BITS-1:0]    addr_w;
   logic [ADDR_BITS-1:0]    from_w;
   logic [ADDR_BITS-1:0]    to_w;
   lane_type                lanes [GROUP_COUNT-1:0];
   stage_type               merge_ff;

   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[CFG_ADDR_BITS-1:REG_SHIFT];
   assign pready = 1'b1;
   assign mv4    = !is_v6_ff && masked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_v6_ff     <= 1'b0;
         masked_ff    <= 1'b0;
         from_high_ff <= '0;
         from_low_ff  <= '0;
         to_high_ff   <= '0;
         to_low_ff    <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_IS_V6:     is_v6_ff     <= pwdata[0];
            REG_MASKED:    masked_ff    <= pwdata[0];
            REG_FROM_HIGH: from_high_ff <= pwdata;
            REG_FROM_LOW:  from_low_ff  <= pwdata;
            REG_TO_HIGH:   to_high_ff   <= pwdata;
            REG_TO_LOW:    to_low_ff    <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_IS_V6:     prdata = CFG_DATA_BITS'(is_v6_ff);
         REG_MASKED:    prdata = CFG_DATA_BITS'(masked_ff);
         REG_FROM_HIGH: prdata = from_high_ff;
         REG_FROM_LOW:  prdata = from_low_ff;
         REG_TO_HIGH:   prdata = to_high_ff;
         REG_TO_LOW:    prdata = to_low_ff;
         default:       prdata = '0;
      endcase
   end

   // advance each stage when it is empty or its successor moves
   always_comb begin
      rdy[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (!rdy[k]) begin
            vld_in[k] = vld_ff[k];
         end else if (k == 0) begin
            vld_in[k] = req_valid;
         end else begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         cmd_ff <= req_item.cmd;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   assign addr_w = {req_item.addr_high, req_item.addr_low};
   assign from_w = {from_high_ff, from_low_ff};
   assign to_w   = {to_high_ff, to_low_ff};

   for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_lane
      irsc_lane #(
         .GROUP_WIDTH(GROUP_WIDTH)
      ) u_lane (
         .clock     (clock),
         .load      (rdy[0]),
         .active    (is_v6_ff || (g < V4_GROUPS)),
         .last      (g == V4_GROUPS - 1),
         .mv4       (mv4),
         .addr_slot (slot_of(addr_w, g)),
         .lo_slot   (slot_of(from_w, g)),
         .hi_slot   (slot_of(to_w, g)),
         .lane_ff   (lanes[g])
      );
   end

   irsc_merge #(
      .GROUP_COUNT(GROUP_COUNT)
   ) u_merge (
      .clock    (clock),
      .load     (rdy[1]),
      .cmd      (cmd_ff),
      .mv4      (mv4),
      .lanes    (lanes),
      .stage_ff (merge_ff)
   );

   irsc_chain #(
      .GROUP_COUNT(GROUP_COUNT)
   ) u_chain (
      .clock    (clock),
      .load     (rdy[NS-1:2]),
      .stage_in (merge_ff),
      .rsp_ff   (rsp_item)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipe not empty after reset");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output register is empty");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("input accepted into a full stalled pipe");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !rdy[1]) |=> vld_ff[0])
      else $error("lane stage dropped an item while stalled");

   a_volume_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.volume != '0)) |->
         ((rsp_item.out_high == '0) && (rsp_item.out_low == '0) && !rsp_item.ok))
      else $error("volume result carries address or ok bits");

endmodule

// File: hdl/irsc_lane.sv
// One address group lane: bound compares, step values and group count, registered.
module irsc_lane import irsc_pkg::*; #(
   parameter int GROUP_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 active,
   input  logic                 last,
   input  logic                 mv4,
   input  logic [SLOT_BITS-1:0] addr_slot,
   input  logic [SLOT_BITS-1:0] lo_slot,
   input  logic [SLOT_BITS-1:0] hi_slot,
   output lane_type             lane_ff
);

   logic [GROUP_WIDTH-1:0] a;
   logic [GROUP_WIDTH-1:0] lo;
   logic [GROUP_WIDTH-1:0] hi;
   logic [GROUP_WIDTH-1:0] inc;
   logic [GROUP_WIDTH-1:0] carry;
   logic [GROUP_WIDTH-1:0] first;
   lane_type               lane_in;

   always_comb begin
      a     = addr_slot[GROUP_WIDTH-1:0];
      lo    = lo_slot[GROUP_WIDTH-1:0];
      hi    = hi_slot[GROUP_WIDTH-1:0];
      inc   = a + GROUP_WIDTH'(1);
      carry = (lo < hi) ? lo : a;
      first = (last && mv4) ? lo + GROUP_WIDTH'(1) : lo;

      lane_in.first_val = SLOT_BITS'(first);
      lane_in.inc_val   = SLOT_BITS'(inc);
      lane_in.carry_val = SLOT_BITS'(carry);
      lane_in.keep_val  = SLOT_BITS'(a);
      lane_in.lt        = a < hi;
      lane_in.in_rng    = (a >= lo) && (a <= hi);
      lane_in.empty     = hi < lo;
      lane_in.eq_inc    = inc == hi;
      lane_in.eq_carry  = carry == hi;
      lane_in.eq_keep   = a == hi;
      lane_in.cnt       = CNT_BITS'(hi) - CNT_BITS'(lo) + CNT_BITS'(1);

      if (!active) begin
         lane_in          = '0;
         lane_in.in_rng   = 1'b1;
         lane_in.eq_inc   = 1'b1;
         lane_in.eq_carry = 1'b1;
         lane_in.eq_keep  = 1'b1;
         lane_in.cnt      = CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// File: hdl/irsc_merge.sv
// Merge stage: carry search, address assembly, membership and product start.
module irsc_merge import irsc_pkg::*; #(
   parameter int GROUP_COUNT = 8
) (
   input  logic       clock,
   input  logic       load,
   input  logic [1:0] cmd,
   input  logic       mv4,
   input  lane_type   lanes [GROUP_COUNT-1:0],
   output stage_type  stage_ff
);

   localparam int SEL_BITS = $clog2(GROUP_COUNT);

   logic [SEL_BITS-1:0]  sel;
   logic                 found;
   logic                 all_eq;
   logic                 all_in;
   logic                 any_empty;
   logic [ADDR_BITS-1:0] first_w;
   logic [ADDR_BITS-1:0] next_w;
   stage_type            stage_in;

   always_comb begin
      sel       = '0;
      found     = 1'b0;
      first_w   = '0;
      next_w    = '0;
      all_eq    = 1'b1;
      all_in    = 1'b1;
      any_empty = 1'b0;

      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (lanes[g].lt) begin
            sel   = SEL_BITS'(g);
            found = 1'b1;
         end
      end

      for (int g = 0; g < GROUP_COUNT; g++) begin
         first_w[ADDR_BITS-1-SLOT_BITS*g -: SLOT_BITS] = lanes[g].first_val;
         if (found && (SEL_BITS'(g) == sel)) begin
            next_w[ADDR_BITS-1-SLOT_BITS*g -: SLOT_BITS] = lanes[g].inc_val;
            all_eq = all_eq & lanes[g].eq_inc;
         end else if (!found || (SEL_BITS'(g) > sel)) begin
            next_w[ADDR_BITS-1-SLOT_BITS*g -: SLOT_BITS] = lanes[g].carry_val;
            all_eq = all_eq & lanes[g].eq_carry;
         end else begin
            next_w[ADDR_BITS-1-SLOT_BITS*g -: SLOT_BITS] = lanes[g].keep_val;
            all_eq = all_eq & lanes[g].eq_keep;
         end
         all_in    = all_in & lanes[g].in_rng;
         any_empty = any_empty | lanes[g].empty;
      end

      stage_in       = '0;
      stage_in.mv4   = mv4;
      stage_in.empty = any_empty;
      stage_in.prod  = WORD_BITS'(lanes[0].cnt);
      for (int g = 0; g < MAX_GROUPS; g++) begin
         stage_in.cnt[g] = CNT_BITS'(1);
         if (g < GROUP_COUNT) begin
            stage_in.cnt[g] = lanes[g].cnt;
         end
      end

      case (cmd)
         CMD_FIRST: begin
            {stage_in.out_high, stage_in.out_low} = first_w;
            stage_in.ok = 1'b1;
         end
         CMD_NEXT: begin
            {stage_in.out_high, stage_in.out_low} = next_w;
            stage_in.ok = found && !(mv4 && all_eq);
         end
         CMD_CHECK: begin
            stage_in.ok = all_in;
         end
         default: begin
            stage_in.is_vol = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: hdl/irsc_chain.sv
// Saturating product chain over group counts and final result register.
module irsc_chain import irsc_pkg::*; #(
   parameter int GROUP_COUNT = 8
) (
   input  logic                   clock,
   input  logic [GROUP_COUNT-1:0] load,
   input  stage_type              stage_in,
   output rsp_type                rsp_ff
);

   localparam int PP_BITS   = 32 + CNT_BITS;
   localparam int FULL_BITS = WORD_BITS + CNT_BITS;

   stage_type mul_ff [GROUP_COUNT-1:1];
   stage_type fin;
   rsp_type   rsp_in;

   for (genvar k = 1; k < GROUP_COUNT; k++) begin : g_mul
      stage_type              prev;
      stage_type              nxt;
      logic [PP_BITS-1:0]     pp_lo;
      logic [PP_BITS-1:0]     pp_hi;
      logic [FULL_BITS-1:0]   full;

      if (k == 1) begin : g_head
         assign prev = stage_in;
      end else begin : g_body
         assign prev = mul_ff[k-1];
      end

      always_comb begin
         pp_lo    = prev.prod[31:0] * prev.cnt[k];
         pp_hi    = prev.prod[WORD_BITS-1:32] * prev.cnt[k];
         full     = {pp_hi, 32'b0} + FULL_BITS'(pp_lo);
         nxt      = prev;
         nxt.prod = full[WORD_BITS-1:0];
         nxt.sat  = prev.sat | (|full[FULL_BITS-1:WORD_BITS]);
      end

      always_ff @(posedge clock) begin
         if (load[k-1]) begin
            mul_ff[k] <= nxt;
         end
      end
   end

   assign fin = mul_ff[GROUP_COUNT-1];

   always_comb begin
      rsp_in.out_high = fin.out_high;
      rsp_in.out_low  = fin.out_low;
      rsp_in.ok       = fin.ok;
      if (!fin.is_vol || fin.empty) begin
         rsp_in.volume = '0;
      end else if (fin.sat) begin
         rsp_in.volume = '1;
      end else if (fin.mv4) begin
         rsp_in.volume = (fin.prod >= WORD_BITS'(2)) ? fin.prod - WORD_BITS'(2) : '0;
      end else begin
         rsp_in.volume = fin.prod;
      end
   end

   always_ff @(posedge clock) begin
      if (load[GROUP_COUNT-1]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
